>>> sv/nft_pkg.sv
// Package for the nozzle flow derivative block: fixed point helpers,
// log table and shared item types. No dependencies.
`default_nettype none
package nft_pkg;

    localparam int unsigned W = 32;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic [1:0] CFG_IDX = 2'd0;
    localparam logic [1:0] CFG_GAM = 2'd1;
    localparam logic [1:0] CFG_KM  = 2'd2;

    function automatic logic [31:0] ln1p(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0: v = 32'd0;
            5'd1: v = 32'd65095192;
            5'd2: v = 32'd126468572;
            5'd3: v = 32'd184522808;
            5'd4: v = 32'd239598564;
            5'd5: v = 32'd291986604;
            5'd6: v = 32'd341937090;
            5'd7: v = 32'd389666807;
            5'd8: v = 32'd435364845;
            5'd9: v = 32'd479197128;
            5'd10: v = 32'd521310048;
            5'd11: v = 32'd561833416;
            5'd12: v = 32'd600882877;
            5'd13: v = 32'd638561895;
            5'd14: v = 32'd674963409;
            5'd15: v = 32'd710171213;
            default: v = 32'd744261118;
        endcase
        return v;
    endfunction

    // clamp a wide value to 32 bits signed; ovf reports a clamp
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v,
                                                 output logic ovf);
        ovf = 1'b0;
        if (v > 96'(S32_MAX)) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < 96'(S32_MIN)) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    typedef struct packed {
        logic        bad;
        logic        sat;
    } t_flags;

endpackage
`default_nettype wire

>>> sv/nft_mul.sv
// Registered fixed point multiplier with saturation: (a*b)>>>FRAC, floor.
// Uses nft_pkg.
`default_nettype none
module nft_mul #(
    parameter int FRAC_BITS = 24
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire  signed [31:0]  i_a,
    input  wire  signed [31:0]  i_b,
    output logic signed [31:0]  o_p,
    output logic                o_ovf
);
    import nft_pkg::*;
    logic signed [63:0] w_prod;
    logic signed [95:0] w_sh;
    logic signed [31:0] n_p;
    logic               n_ovf;
    assign w_prod = i_a * i_b;
    assign w_sh   = 96'(w_prod) >>> FRAC_BITS;
    always_comb n_p = sat32(w_sh, n_ovf);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p   <= n_p;
            o_ovf <= n_ovf;
        end
    end
endmodule
`default_nettype wire

>>> sv/nft_log.sv
// Log of a raw area value in Q.30 without exponent bias, two stages.
// Uses nft_pkg table.
`default_nettype none
module nft_log (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire  [30:0]        i_x,
    output logic signed [37:0] o_ln
);
    import nft_pkg::*;
    logic [4:0]  w_n;
    logic [29:0] w_m;
    logic [4:0]  r_n;
    logic [3:0]  r_k;
    logic [25:0] r_t;
    logic [31:0] w_lo;
    logic [31:0] w_hi;
    logic [58:0] w_ip;
    always_comb begin
        w_n = 5'd0;
        for (int i = 1; i <= 30; i++)
            if (i_x[i]) w_n = 5'(i);
        w_m = 30'((i_x << (5'd30 - w_n)));
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= w_n;
            r_k <= w_m[29:26];
            r_t <= w_m[25:0];
        end
    end
    assign w_lo = ln1p({1'b0, r_k});
    assign w_hi = ln1p(5'({1'b0, r_k}) + 5'd1);
    assign w_ip = (w_hi - w_lo) * r_t;
    always_ff @(posedge i_clk) begin
        if (i_en)
            o_ln <= 38'(r_n) * 38'd744261118 + 38'(w_lo) + 38'(w_ip >> 26);
    end
endmodule
`default_nettype wire

>>> sv/nft_div.sv
// Pipelined signed divider: (num<<FRAC)/den toward zero, one quotient bit
// per stage, saturated, registered output. Uses nft_pkg.
`default_nettype none
module nft_div #(
    parameter int FRAC_BITS = 24
) (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire  signed [31:0] i_num,
    input  wire  signed [31:0] i_den,
    output logic signed [31:0] o_q,
    output logic               o_ovf
);
    import nft_pkg::*;
    localparam int NB = 32 + FRAC_BITS;
    logic [NB-1:0] r_n   [NB+1];
    logic [NB-1:0] r_q   [NB+1];
    logic [32:0]   r_r   [NB+1];
    logic [31:0]   r_d   [NB+1];
    logic          r_neg [NB+1];
    logic [32:0]   w_r   [NB];
    logic [32:0]   w_t   [NB];
    logic signed [95:0] w_v;
    logic signed [31:0] n_q;
    logic          n_ovf;
    always_comb begin
        for (int s = 0; s < NB; s++) begin
            w_t[s] = {r_r[s][31:0], r_n[s][NB-1-s]};
            w_r[s] = (w_t[s] >= {1'b0, r_d[s]}) ? w_t[s] - {1'b0, r_d[s]} : w_t[s];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= NB'(i_num[31] ? 33'(-34'(i_num)) : 33'(i_num)) << FRAC_BITS;
            r_q[0]   <= '0;
            r_r[0]   <= '0;
            r_d[0]   <= i_den;
            r_neg[0] <= i_num[31];
            for (int s = 0; s < NB; s++) begin
                r_n[s+1]   <= r_n[s];
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                r_r[s+1]   <= w_r[s];
                r_q[s+1]   <= r_q[s] | (NB'(w_t[s] >= {1'b0, r_d[s]}) << (NB-1-s));
            end
        end
    end
    always_comb begin
        if (r_q[NB] > NB'(64'h100000000)) w_v = 96'sh100000000;
        else w_v = 96'(r_q[NB]);
        if (r_neg[NB]) w_v = -w_v;
        n_q = sat32(w_v, n_ovf);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q   <= n_q;
            o_ovf <= n_ovf;
        end
    end
endmodule
`default_nettype wire

>>> sv/nozzle_flow_time_derivatives.sv
// Top level of the nozzle flow derivative pipeline.
// Uses nft_pkg, nft_mul, nft_log, nft_div.
//
// Input channel: i_valid / o_stall with one port per field. Output channel:
// o_valid / i_stall. Configuration: i_cfg_valid / o_cfg_ready, index and data,
// always ready; write only while no item is in flight.
// The pipeline takes one item per cycle while o_stall is low. The divider sets
// most of its depth (one quotient bit per stage plus its output register). A
// stall freezes every stage in place; o_stall follows i_stall whenever the
// output register holds an item. Reset clears all valid bits and loads the
// register defaults.
`default_nettype none
module nozzle_flow_time_derivatives #(
    parameter int FRAC_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_opcode,
    input  wire  signed [31:0] i_rho_here,
    input  wire  signed [31:0] i_rho_near,
    input  wire  signed [31:0] i_vel_here,
    input  wire  signed [31:0] i_vel_near,
    input  wire  signed [31:0] i_temp_here,
    input  wire  signed [31:0] i_temp_near,
    input  wire  [30:0] i_area_here,
    input  wire  [30:0] i_area_near,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output logic        o_valid,
    input  wire         i_stall,
    output logic signed [31:0] o_drho_dt,
    output logic signed [31:0] o_dvel_dt,
    output logic signed [31:0] o_dtemp_dt,
    output logic [1:0]  o_status
);
    import nft_pkg::*;
    localparam int DL = 33 + FRAC_BITS;
    localparam int NS = 8 + DL;

    logic [30:0] r_idx;
    logic [24:0] r_gam;
    logic [24:0] r_km;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 31'd16777216;
            r_gam <= 25'd11983726;
            r_km  <= 25'd6710886;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX: r_idx <= i_cfg_data[30:0];
                CFG_GAM: r_gam <= i_cfg_data[24:0];
                CFG_KM:  r_km  <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [NS-1:0] r_v;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v[NS-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en)  r_v <= {r_v[NS-2:0], i_valid};
    end

    // stage 1: differences, bad flag, log stage A
    logic signed [31:0] r1_rho, r1_vel, r1_tmp, r1_dr, r1_dv, r1_dt;
    logic r1_neg, r1_bad, r1_sat;
    logic o0, o1, o2;
    logic signed [31:0] n_dr, n_dv, n_dt;
    logic signed [33:0] w_a, w_b, w_c;
    always_comb begin
        w_a = 34'(i_rho_near) - 34'(i_rho_here);
        w_b = 34'(i_vel_near) - 34'(i_vel_here);
        w_c = 34'(i_temp_near) - 34'(i_temp_here);
        if (i_opcode) begin
            w_a = -w_a; w_b = -w_b; w_c = -w_c;
        end
        n_dr = sat32(96'(w_a), o0);
        n_dv = sat32(96'(w_b), o1);
        n_dt = sat32(96'(w_c), o2);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rho <= i_rho_here; r1_vel <= i_vel_here; r1_tmp <= i_temp_here;
            r1_dr <= n_dr; r1_dv <= n_dv; r1_dt <= n_dt;
            r1_neg <= i_opcode;
            r1_sat <= o0 | o1 | o2;
            r1_bad <= (i_rho_here <= 0) || (i_rho_near <= 0) ||
                      (i_area_here == '0) || (i_area_near == '0);
        end
    end
    logic signed [37:0] w_lh, w_ln;
    nft_log u_logh (.i_clk, .i_en(en), .i_x(i_area_here), .o_ln(w_lh));
    nft_log u_logn (.i_clk, .i_en(en), .i_x(i_area_near), .o_ln(w_ln));
    // stage 2: hold
    logic signed [31:0] r2_rho, r2_vel, r2_tmp, r2_dr, r2_dv, r2_dt;
    logic r2_neg, r2_bad, r2_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rho <= r1_rho; r2_vel <= r1_vel; r2_tmp <= r1_tmp;
            r2_dr <= r1_dr; r2_dv <= r1_dv; r2_dt <= r1_dt;
            r2_neg <= r1_neg; r2_bad <= r1_bad; r2_sat <= r1_sat;
        end
    end
    // stage 3: log difference to FRAC_BITS
    logic signed [31:0] r3_rho, r3_vel, r3_tmp, r3_dr, r3_dv, r3_dt, r3_dl;
    logic r3_bad, r3_sat;
    logic signed [95:0] w_dl;
    logic signed [31:0] n_dl;
    logic o3;
    always_comb begin
        w_dl = 96'(w_ln) - 96'(w_lh);
        if (r2_neg) w_dl = -w_dl;
        if (FRAC_BITS >= 30) w_dl = w_dl <<< ((FRAC_BITS - 30) & 63);
        else w_dl = w_dl >>> ((30 - FRAC_BITS) & 63);
        n_dl = sat32(w_dl, o3);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_rho <= r2_rho; r3_vel <= r2_vel; r3_tmp <= r2_tmp;
            r3_dr <= r2_dr; r3_dv <= r2_dv; r3_dt <= r2_dt; r3_dl <= n_dl;
            r3_bad <= r2_bad; r3_sat <= r2_sat | o3;
        end
    end
    // stage 4: gradients, rho*vel, k*T
    logic signed [31:0] gr, gv, gt, ga, rv, kt;
    logic og0, og1, og2, og3, og4, og5;
    logic signed [31:0] w_idx, w_gam, w_km;
    assign w_idx = {1'b0, r_idx};
    assign w_gam = {7'd0, r_gam};
    assign w_km  = {7'd0, r_km};
    nft_mul #(FRAC_BITS) u_gr (.i_clk, .i_en(en), .i_a(r3_dr), .i_b(w_idx), .o_p(gr), .o_ovf(og0));
    nft_mul #(FRAC_BITS) u_gv (.i_clk, .i_en(en), .i_a(r3_dv), .i_b(w_idx), .o_p(gv), .o_ovf(og1));
    nft_mul #(FRAC_BITS) u_gt (.i_clk, .i_en(en), .i_a(r3_dt), .i_b(w_idx), .o_p(gt), .o_ovf(og2));
    nft_mul #(FRAC_BITS) u_ga (.i_clk, .i_en(en), .i_a(r3_dl), .i_b(w_idx), .o_p(ga), .o_ovf(og3));
    nft_mul #(FRAC_BITS) u_rv (.i_clk, .i_en(en), .i_a(r3_rho), .i_b(r3_vel), .o_p(rv), .o_ovf(og4));
    nft_mul #(FRAC_BITS) u_kt (.i_clk, .i_en(en), .i_a(w_km), .i_b(r3_tmp), .o_p(kt), .o_ovf(og5));
    logic signed [31:0] r4_rho, r4_vel, r4_tmp;
    logic r4_bad, r4_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_rho <= r3_rho; r4_vel <= r3_vel; r4_tmp <= r3_tmp;
            r4_bad <= r3_bad; r4_sat <= r3_sat;
        end
    end
    logic s4;
    assign s4 = r4_sat | og0 | og1 | og2 | og3 | og4 | og5;
    // stage 5: second products
    logic signed [31:0] p_vr, p_rv, p_rva, p_vv, p_tr, p_vt, p_va;
    logic op0, op1, op2, op3, op4, op5, op6;
    nft_mul #(FRAC_BITS) u_p0 (.i_clk, .i_en(en), .i_a(r4_vel), .i_b(gr), .o_p(p_vr), .o_ovf(op0));
    nft_mul #(FRAC_BITS) u_p1 (.i_clk, .i_en(en), .i_a(r4_rho), .i_b(gv), .o_p(p_rv), .o_ovf(op1));
    nft_mul #(FRAC_BITS) u_p2 (.i_clk, .i_en(en), .i_a(rv), .i_b(ga), .o_p(p_rva), .o_ovf(op2));
    nft_mul #(FRAC_BITS) u_p3 (.i_clk, .i_en(en), .i_a(r4_vel), .i_b(gv), .o_p(p_vv), .o_ovf(op3));
    nft_mul #(FRAC_BITS) u_p4 (.i_clk, .i_en(en), .i_a(r4_tmp), .i_b(gr), .o_p(p_tr), .o_ovf(op4));
    nft_mul #(FRAC_BITS) u_p5 (.i_clk, .i_en(en), .i_a(r4_vel), .i_b(gt), .o_p(p_vt), .o_ovf(op5));
    nft_mul #(FRAC_BITS) u_p6 (.i_clk, .i_en(en), .i_a(r4_vel), .i_b(ga), .o_p(p_va), .o_ovf(op6));
    logic signed [31:0] r5_rho, r5_gt, r5_gv, r5_kt;
    logic r5_bad, r5_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_rho <= r4_rho; r5_gt <= gt; r5_gv <= gv; r5_kt <= kt;
            r5_bad <= r4_bad; r5_sat <= s4;
        end
    end
    // stage 6: r0 and the sum for r2; feed the divider
    logic signed [31:0] n_r0, n_s2;
    logic oa, ob;
    always_comb begin
        n_r0 = sat32(96'(-96'(p_vr) - 96'(p_rv) - 96'(p_rva)), oa);
        n_s2 = sat32(96'(r5_gv) + 96'(p_va), ob);
    end
    logic signed [31:0] w_q;
    logic oq;
    nft_div #(FRAC_BITS) u_div (.i_clk, .i_en(en), .i_num(p_tr), .i_den(r5_rho),
                                .o_q(w_q), .o_ovf(oq));
    // delay line alongside the divider
    logic signed [31:0] d_r0 [DL+1];
    logic signed [31:0] d_s2 [DL+1];
    logic signed [31:0] d_gt [DL+1];
    logic signed [31:0] d_vv [DL+1];
    logic signed [31:0] d_vt [DL+1];
    logic signed [31:0] d_kt [DL+1];
    logic               d_bad [DL+1];
    logic               d_sat [DL+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            d_r0[0] <= n_r0; d_s2[0] <= n_s2; d_gt[0] <= r5_gt; d_vv[0] <= p_vv;
            d_vt[0] <= p_vt; d_kt[0] <= r5_kt; d_bad[0] <= r5_bad;
            d_sat[0] <= r5_sat | op0 | op1 | op2 | op3 | op4 | op5 | op6 | oa | ob;
            for (int s = 0; s < DL; s++) begin
                d_r0[s+1] <= d_r0[s]; d_s2[s+1] <= d_s2[s]; d_gt[s+1] <= d_gt[s];
                d_vv[s+1] <= d_vv[s]; d_vt[s+1] <= d_vt[s]; d_kt[s+1] <= d_kt[s];
                d_bad[s+1] <= d_bad[s]; d_sat[s+1] <= d_sat[s];
            end
        end
    end
    // after divider: gt + q, then two final products
    logic signed [31:0] n_s1;
    logic oc;
    always_comb n_s1 = sat32(96'(d_gt[DL]) + 96'(w_q), oc);
    logic signed [31:0] w_f1, w_f2;
    logic of1, of2;
    nft_mul #(FRAC_BITS) u_f1 (.i_clk, .i_en(en), .i_a(w_gam), .i_b(n_s1), .o_p(w_f1), .o_ovf(of1));
    nft_mul #(FRAC_BITS) u_f2 (.i_clk, .i_en(en), .i_a(d_kt[DL]), .i_b(d_s2[DL]),
                               .o_p(w_f2), .o_ovf(of2));
    logic signed [31:0] r7_r0, r7_vv, r7_vt;
    logic r7_bad, r7_sat;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_r0 <= d_r0[DL]; r7_vv <= d_vv[DL]; r7_vt <= d_vt[DL];
            r7_bad <= d_bad[DL]; r7_sat <= d_sat[DL] | oq | oc;
        end
    end
    // final: r1, r2, status into output register
    logic signed [31:0] n_r1, n_r2;
    logic od, oe, s_all;
    always_comb begin
        n_r1 = sat32(-96'(r7_vv) - 96'(w_f1), od);
        n_r2 = sat32(-96'(r7_vt) - 96'(w_f2), oe);
        s_all = r7_sat | of1 | of2 | od | oe;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r7_bad) begin
                o_drho_dt <= '0; o_dvel_dt <= '0; o_dtemp_dt <= '0;
                o_status <= ST_BAD;
            end else begin
                o_drho_dt <= r7_r0; o_dvel_dt <= n_r1; o_dtemp_dt <= n_r2;
                o_status <= s_all ? ST_SAT : ST_OK;
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_nozzle_flow_time_derivatives.sv
// Testbench for nozzle_flow_time_derivatives: directed and random grid points,
// checked against an in-bench model of the MacCormack derivative arithmetic.
// Depends on nft_pkg and the block's RTL only.
`default_nettype none
module tb_nozzle_flow_time_derivatives;
    timeunit 1ns;
    timeprecision 1ps;
    import nft_pkg::*;

    localparam int FRAC = 24;
    localparam int LATENCY = 8 + 33 + FRAC;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        bit                 corr;
        logic signed [31:0] rho_h, rho_n, vel_h, vel_n, tmp_h, tmp_n;
        logic [30:0]        area_h, area_n;
    } t_point;

    typedef struct {
        logic signed [31:0] drho, dvel, dtemp;
        logic [1:0]         status;
    } t_deriv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_opcode = 1'b0;
    logic signed [31:0] i_rho_here = '0, i_rho_near = '0, i_vel_here = '0;
    logic signed [31:0] i_vel_near = '0, i_temp_here = '0, i_temp_near = '0;
    logic [30:0] i_area_here = '0, i_area_near = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_IDX;
    logic [31:0] i_cfg_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_drho_dt, o_dvel_dt, o_dtemp_dt;
    logic [1:0] o_status;

    nozzle_flow_time_derivatives #(.FRAC_BITS(FRAC)) DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies
    longint inv_dx = 16777216;
    longint inv_gamma = 11983726;
    longint gamma_m1 = 6710886;

    t_deriv deriv_q[$];
    int errors = 0;
    int n_points = 0;
    int n_results = 0;
    int n_sat = 0;
    int n_bad = 0;
    int burst_left = 0;
    longint cycles = 0;
    bit clipped;

    longint ln1p_q30[17] = '{0, 65095192, 126468572, 184522808, 239598564, 291986604,
        341937090, 389666807, 435364845, 479197128, 521310048, 561833416, 600882877,
        638561895, 674963409, 710171213, 744261118};

    function automatic longint clip(longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip((a * b) >>> FRAC);
    endfunction

    // (num << FRAC) / den toward zero, den positive
    function automatic longint qdiv(longint num, longint den);
        longint unsigned n, d, q, r;
        int i;
        n = (num < 0) ? -num : num;
        d = den;
        q = n / d;
        r = n % d;
        for (i = 0; i < FRAC && q <= 64'h100000000; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
        end
        if (q > 64'h100000000) q = 64'h100000000;
        return clip((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint log_q30(longint x);
        int n;
        longint m, t;
        int k;
        n = 30;
        while (n > 0 && x[n] == 1'b0) n--;
        m = (x << (30 - n)) & 64'h3FFFFFFF;
        k = int'((m >> 26) & 15);
        t = m & 64'h3FFFFFF;
        return n * ln1p_q30[16] + ln1p_q30[k] + (((ln1p_q30[k+1] - ln1p_q30[k]) * t) >>> 26);
    endfunction

    function automatic t_deriv flow_derivs(t_point p);
        t_deriv o;
        longint rho, rho_n, vel, vel_n, tmp, tmp_n, ah, an;
        longint dr, dv, dt, dl, gr, gv, gt, ga;
        rho = longint'(p.rho_h); rho_n = longint'(p.rho_n);
        vel = longint'(p.vel_h); vel_n = longint'(p.vel_n);
        tmp = longint'(p.tmp_h); tmp_n = longint'(p.tmp_n);
        ah = longint'(p.area_h); an = longint'(p.area_n);
        clipped = 1'b0;
        if (rho <= 0 || rho_n <= 0 || ah == 0 || an == 0) begin
            o.drho = '0; o.dvel = '0; o.dtemp = '0; o.status = ST_BAD;
            return o;
        end
        if (p.corr) begin
            dr = clip(rho - rho_n);
            dv = clip(vel - vel_n);
            dt = clip(tmp - tmp_n);
            dl = log_q30(ah) - log_q30(an);
        end else begin
            dr = clip(rho_n - rho);
            dv = clip(vel_n - vel);
            dt = clip(tmp_n - tmp);
            dl = log_q30(an) - log_q30(ah);
        end
        dl = clip(dl >>> (30 - FRAC));
        gr = qmul(dr, inv_dx);
        gv = qmul(dv, inv_dx);
        gt = qmul(dt, inv_dx);
        ga = qmul(dl, inv_dx);
        o.drho = 32'(clip(-qmul(vel, gr) - qmul(rho, gv) - qmul(qmul(rho, vel), ga)));
        o.dvel = 32'(clip(-qmul(vel, gv) -
                 qmul(inv_gamma, clip(gt + qdiv(qmul(tmp, gr), rho)))));
        o.dtemp = 32'(clip(-qmul(vel, gt) -
                  qmul(qmul(gamma_m1, tmp), clip(gv + qmul(vel, ga)))));
        o.status = clipped ? ST_SAT : ST_OK;
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, deriv_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern: free-running stretches, random stalls, long holds
    int stall_mode = 0;
    int stall_span = 0;
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(5, 60);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            2: i_stall <= ($urandom_range(0, 7) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_deriv e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (deriv_q.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end else begin
                e = deriv_q.pop_front();
                n_results++;
                if (o_drho_dt !== e.drho) begin
                    $display("%0t: drho_dt expected %0d actual %0d", $time, e.drho, o_drho_dt);
                    errors++;
                end
                if (o_dvel_dt !== e.dvel) begin
                    $display("%0t: dvel_dt expected %0d actual %0d", $time, e.dvel, o_dvel_dt);
                    errors++;
                end
                if (o_dtemp_dt !== e.dtemp) begin
                    $display("%0t: dtemp_dt expected %0d actual %0d", $time, e.dtemp,
                             o_dtemp_dt);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic send_point(input t_point p);
        int gap;
        i_valid <= 1'b1;
        i_opcode <= p.corr;
        i_rho_here <= p.rho_h;
        i_rho_near <= p.rho_n;
        i_vel_here <= p.vel_h;
        i_vel_near <= p.vel_n;
        i_temp_here <= p.tmp_h;
        i_temp_near <= p.tmp_n;
        i_area_here <= p.area_h;
        i_area_near <= p.area_n;
        do @(posedge i_clk); while (o_stall);
        deriv_q.push_back(flow_derivs(p));
        if (deriv_q[$].status == ST_SAT) n_sat++;
        if (deriv_q[$].status == ST_BAD) n_bad++;
        n_points++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (deriv_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_IDX: inv_dx = longint'(data & 32'h7FFFFFFF);
            CFG_GAM: inv_gamma = longint'(data & 32'h1FFFFFF);
            CFG_KM:  gamma_m1 = longint'(data & 32'h1FFFFFF);
            default: ;
        endcase
    endtask

    function automatic t_point smooth_point();
        t_point p;
        p.corr = 1'($urandom_range(0, 1));
        p.rho_h = $urandom_range(1 << 21, 1 << 26);
        p.rho_n = p.rho_h + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.vel_h = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
        p.vel_n = p.vel_h + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.tmp_h = $urandom_range(1 << 22, 1 << 26);
        p.tmp_n = p.tmp_h + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        p.area_h = 31'($urandom_range(1, 32'h7FFFFFFF >> $urandom_range(0, 24)));
        p.area_n = 31'(p.area_h + $urandom_range(0, 1 << 20));
        if (p.area_n == 0) p.area_n = 1;
        return p;
    endfunction

    function automatic t_point noise_point();
        t_point p;
        p.corr = 1'($urandom_range(0, 1));
        p.rho_h = $urandom();
        p.rho_n = $urandom();
        p.vel_h = $urandom();
        p.vel_n = $urandom();
        p.tmp_h = $urandom();
        p.tmp_n = $urandom();
        p.area_h = 31'($urandom());
        p.area_n = 31'($urandom());
        // keep some noise past the bad-input check
        if ($urandom_range(0, 1) == 0) begin
            p.rho_h[31] = 1'b0;
            p.rho_n[31] = 1'b0;
            if (p.rho_h == 0) p.rho_h = 1;
            if (p.rho_n == 0) p.rho_n = 1;
            if (p.area_h == 0) p.area_h = 1;
            if (p.area_n == 0) p.area_n = 1;
        end
        return p;
    endfunction

    task automatic test_directed_points();
        t_point p;
        int i;
        for (i = 0; i < 2; i++) begin
            p = '{corr: i[0], rho_h: 32'sh01000000, rho_n: 32'sh01100000,
                  vel_h: 32'sh00800000, vel_n: 32'sh00900000,
                  tmp_h: 32'sh01000000, tmp_n: 32'sh00F00000,
                  area_h: 31'h01000000, area_n: 31'h00E00000};
            send_point(p);
            // full-scale values push the arithmetic into saturation
            p = '{corr: i[0], rho_h: 32'sh7FFFFFFF, rho_n: 32'sh00000001,
                  vel_h: 32'sh80000000, vel_n: 32'sh7FFFFFFF,
                  tmp_h: 32'sh7FFFFFFF, tmp_n: 32'sh80000000,
                  area_h: 31'h7FFFFFFF, area_n: 31'h00000001};
            send_point(p);
            p = '{corr: i[0], rho_h: 32'sh00000001, rho_n: 32'sh7FFFFFFF,
                  vel_h: 32'sh7FFFFFFF, vel_n: 32'sh80000000,
                  tmp_h: 32'sh80000000, tmp_n: 32'sh7FFFFFFF,
                  area_h: 31'h00000001, area_n: 31'h7FFFFFFF};
            send_point(p);
            // zero and negative density, zero area on either side
            p = smooth_point(); p.corr = i[0]; p.rho_h = 0; send_point(p);
            p = smooth_point(); p.corr = i[0]; p.rho_n = 32'sh80000000; send_point(p);
            p = smooth_point(); p.corr = i[0]; p.area_h = 0; send_point(p);
            p = smooth_point(); p.corr = i[0]; p.area_n = 0; send_point(p);
            // equal neighbours: all differences vanish
            p = smooth_point(); p.corr = i[0];
            p.rho_n = p.rho_h; p.vel_n = p.vel_h; p.tmp_n = p.tmp_h; p.area_n = p.area_h;
            send_point(p);
            // small density amplifies the quotient
            p = smooth_point(); p.corr = i[0]; p.rho_h = 1; send_point(p);
            p = smooth_point(); p.corr = i[0]; send_point(p);
        end
        drain();
    endtask

    task automatic test_register_extremes();
        t_point p;
        int s, i;
        logic [31:0] set_dx[4] = '{32'd0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd1 << 20};
        logic [31:0] set_g[4] = '{32'd16777216, 32'd0, 32'h1FFFFFF, 32'd8388608};
        logic [31:0] set_k[4] = '{32'd0, 32'd16777216, 32'hFFFFFFFF, 32'd4194304};
        for (s = 0; s < 4; s++) begin
            write_reg(CFG_IDX, set_dx[s]);
            write_reg(CFG_GAM, set_g[s]);
            write_reg(CFG_KM, set_k[s]);
            for (i = 0; i < 40; i++) begin
                p = ($urandom_range(0, 3) == 0) ? noise_point() : smooth_point();
                send_point(p);
            end
        end
    endtask

    task automatic test_random_phases();
        t_point p;
        int ph, i;
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_IDX, 32'd16777216);
                write_reg(CFG_GAM, 32'd11983726);
                write_reg(CFG_KM, 32'd6710886);
            end else begin
                write_reg(CFG_IDX, $urandom_range(0, 1 << 28));
                write_reg(CFG_GAM, $urandom_range(0, 1 << 24));
                write_reg(CFG_KM, $urandom_range(0, 1 << 24));
            end
            for (i = 0; i < 200; i++) begin
                p = ($urandom_range(0, 4) == 0) ? noise_point() : smooth_point();
                send_point(p);
            end
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_register_extremes();
        test_random_phases();
        $display("sent %0d grid points, checked %0d results (%0d saturated, %0d bad input)",
                 n_points, n_results, n_sat, n_bad);
        $display("both difference directions under several register settings, %0d errors",
                 errors);
        if (errors == 0 && deriv_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
sv/nft_pkg.sv
sv/nft_mul.sv
sv/nft_log.sv
sv/nft_div.sv
sv/nozzle_flow_time_derivatives.sv
tb/tb_nozzle_flow_time_derivatives.sv
